@@ rtl/incremental_pid_four_motor_defines.svh @@
// assertion macros shared by the incremental pid rtl
// the using module must have clk and arst_n in scope
`ifndef INCREMENTAL_PID_FOUR_MOTOR_DEFINES_SVH
`define INCREMENTAL_PID_FOUR_MOTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define IPFM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define IPFM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define IPFM_ASSERT(lbl, prop, msg)
`define IPFM_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/ipfm_pkg.sv @@
// shared types, constants and fixed-point helpers for the four-motor pid
// no dependencies
`default_nettype none
package ipfm_pkg;

	localparam int MOTOR_COUNT = 4;
	localparam int MOTOR_IDX_W = $clog2(MOTOR_COUNT);
	localparam int SPEED_W     = 16;
	localparam int ERR_W       = SPEED_W + 1;
	localparam int OFF_W       = 8;
	localparam int GAIN_W      = 16;
	localparam int MAXSPD_W    = 15;
	localparam int ACTION_W    = 3;
	localparam int SUM_W       = 40;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;
	localparam int FRAC_BITS   = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_COMPUTE = 3'd0,
		ACT_SET_ONE = 3'd1,
		ACT_SET_ALL = 3'd2,
		ACT_SPIN    = 3'd3,
		ACT_STEER   = 3'd4,
		ACT_CLEAR   = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		REG_KP        = 3'd0,
		REG_KI        = 3'd1,
		REG_KD        = 3'd2,
		REG_STEER_KP  = 3'd3,
		REG_STEER_KD  = 3'd4,
		REG_MAX_SPEED = 3'd5
	} reg_idx_t;

	localparam logic [GAIN_W-1:0]   KP_RESET        = 16'd320;
	localparam logic [GAIN_W-1:0]   KI_RESET        = 16'd512;
	localparam logic [GAIN_W-1:0]   KD_RESET        = 16'd102;
	localparam logic [GAIN_W-1:0]   STEER_KP_RESET  = 16'd141;
	localparam logic [GAIN_W-1:0]   STEER_KD_RESET  = 16'd1664;
	localparam logic [MAXSPD_W-1:0] MAX_SPEED_RESET = 15'd32767;

	typedef struct packed {
		logic [GAIN_W-1:0]   kp;
		logic [GAIN_W-1:0]   ki;
		logic [GAIN_W-1:0]   kd;
		logic [GAIN_W-1:0]   steer_kp;
		logic [GAIN_W-1:0]   steer_kd;
		logic [MAXSPD_W-1:0] max_speed;
	} cfg_t;

	typedef struct packed {
		logic                    upd;
		logic signed [OFF_W-1:0] offset;
	} steer_req_t;

	localparam logic signed [SUM_W-1:0] PWM_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] PWM_MIN = SUM_W'(-32768);
	localparam logic signed [SUM_W-1:0] FB_MAX  = SUM_W'(127);
	localparam logic signed [SUM_W-1:0] FB_MIN  = SUM_W'(-128);

	// q32.8 to integer, rounding toward zero
	function automatic logic signed [SUM_W-1:0] q8_trunc(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] mag;
		mag = s[SUM_W-1] ? -s : s;
		mag = mag >>> FRAC_BITS;
		return s[SUM_W-1] ? -mag : mag;
	endfunction

	function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [SUM_W-1:0] s);
		logic signed [SPEED_W-1:0] r;
		if (s > PWM_MAX) begin
			r = PWM_MAX[SPEED_W-1:0];
		end else if (s < PWM_MIN) begin
			r = PWM_MIN[SPEED_W-1:0];
		end else begin
			r = s[SPEED_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [OFF_W-1:0] sat8(input logic signed [SUM_W-1:0] s);
		logic signed [OFF_W-1:0] r;
		if (s > FB_MAX) begin
			r = FB_MAX[OFF_W-1:0];
		end else if (s < FB_MIN) begin
			r = FB_MIN[OFF_W-1:0];
		end else begin
			r = s[OFF_W-1:0];
		end
		return r;
	endfunction

	// one guard bit down to 16 bits
	function automatic logic signed [SPEED_W-1:0] sat17(input logic signed [SPEED_W:0] x);
		logic signed [SPEED_W-1:0] r;
		if (x[SPEED_W] != x[SPEED_W-1]) begin
			r = x[SPEED_W] ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
		end else begin
			r = x[SPEED_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/incremental_pid_four_motor.sv @@
// top level: four-motor incremental velocity pid with target setting
// uses ipfm_pkg, ipfm_regs, ipfm_steer, ipfm_loop
//
//  channel   handshake                        payload
//  item      item_valid / item_ready          action motor_index speed_request
//                                             measured_count line_offset
//  result    result_valid / result_ready      pwm_increment measured_speed target_speed
//  config    psel penable pwrite pready       paddr pwdata prdata
//
// one beat per cycle sustained while result_ready is high; an item passes the input
// stage, then the result register, set by the single pid / target update path
// reset clears all targets, measurements, error history and offset history, and
// loads the default gains; no clearing pass, items are taken right after reset
// result_ready low holds the result; item_ready drops only once the input stage
// is also full
`default_nettype none
module incremental_pid_four_motor (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [ipfm_pkg::PADDR_W-1:0]           paddr,
	input  wire logic [ipfm_pkg::PDATA_W-1:0]           pwdata,
	output logic      [ipfm_pkg::PDATA_W-1:0]           prdata,
	output logic                                        pready,
	input  wire logic                                   item_valid,
	output logic                                        item_ready,
	input  wire logic [ipfm_pkg::ACTION_W-1:0]          action,
	input  wire logic [ipfm_pkg::MOTOR_IDX_W-1:0]       motor_index,
	input  wire logic signed [ipfm_pkg::SPEED_W-1:0]    speed_request,
	input  wire logic signed [ipfm_pkg::SPEED_W-1:0]    measured_count,
	input  wire logic signed [ipfm_pkg::OFF_W-1:0]      line_offset,
	output logic                                        result_valid,
	input  wire logic                                   result_ready,
	output logic signed [ipfm_pkg::SPEED_W-1:0]         pwm_increment,
	output logic signed [ipfm_pkg::SPEED_W-1:0]         measured_speed,
	output logic signed [ipfm_pkg::SPEED_W-1:0]         target_speed
);

	ipfm_pkg::cfg_t                       cfg;
	ipfm_pkg::steer_req_t                 steer_req;
	logic signed [ipfm_pkg::OFF_W-1:0]    fb;

	ipfm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipfm_steer u_steer (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (steer_req),
		.fb     (fb)
	);

	ipfm_loop u_loop (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.fb             (fb),
		.steer_req      (steer_req),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.action         (action),
		.motor_index    (motor_index),
		.speed_request  (speed_request),
		.measured_count (measured_count),
		.line_offset    (line_offset),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.pwm_increment  (pwm_increment),
		.measured_speed (measured_speed),
		.target_speed   (target_speed)
	);

endmodule
`default_nettype wire

@@ rtl/ipfm_regs.sv @@
// apb-style register file holding gains and the speed cap
// uses ipfm_pkg
`default_nettype none
module ipfm_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ipfm_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [ipfm_pkg::PDATA_W-1:0]    pwdata,
	output logic      [ipfm_pkg::PDATA_W-1:0]    prdata,
	output logic                                 pready,
	output ipfm_pkg::cfg_t                       cfg
);

	ipfm_pkg::cfg_t cfg_q;
	logic [2:0]     widx;
	logic           wr_en;

	assign widx   = paddr[ipfm_pkg::PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp        <= ipfm_pkg::KP_RESET;
			cfg_q.ki        <= ipfm_pkg::KI_RESET;
			cfg_q.kd        <= ipfm_pkg::KD_RESET;
			cfg_q.steer_kp  <= ipfm_pkg::STEER_KP_RESET;
			cfg_q.steer_kd  <= ipfm_pkg::STEER_KD_RESET;
			cfg_q.max_speed <= ipfm_pkg::MAX_SPEED_RESET;
		end else if (wr_en) begin
			case (widx)
				ipfm_pkg::REG_KP:        cfg_q.kp        <= pwdata[ipfm_pkg::GAIN_W-1:0];
				ipfm_pkg::REG_KI:        cfg_q.ki        <= pwdata[ipfm_pkg::GAIN_W-1:0];
				ipfm_pkg::REG_KD:        cfg_q.kd        <= pwdata[ipfm_pkg::GAIN_W-1:0];
				ipfm_pkg::REG_STEER_KP:  cfg_q.steer_kp  <= pwdata[ipfm_pkg::GAIN_W-1:0];
				ipfm_pkg::REG_STEER_KD:  cfg_q.steer_kd  <= pwdata[ipfm_pkg::GAIN_W-1:0];
				ipfm_pkg::REG_MAX_SPEED: cfg_q.max_speed <= pwdata[ipfm_pkg::MAXSPD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			ipfm_pkg::REG_KP:        prdata = ipfm_pkg::PDATA_W'(cfg_q.kp);
			ipfm_pkg::REG_KI:        prdata = ipfm_pkg::PDATA_W'(cfg_q.ki);
			ipfm_pkg::REG_KD:        prdata = ipfm_pkg::PDATA_W'(cfg_q.kd);
			ipfm_pkg::REG_STEER_KP:  prdata = ipfm_pkg::PDATA_W'(cfg_q.steer_kp);
			ipfm_pkg::REG_STEER_KD:  prdata = ipfm_pkg::PDATA_W'(cfg_q.steer_kd);
			ipfm_pkg::REG_MAX_SPEED: prdata = ipfm_pkg::PDATA_W'(cfg_q.max_speed);
			default:                 prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/ipfm_steer.sv @@
// line-offset pd correction with its previous-offset register
// uses ipfm_pkg
`default_nettype none
module ipfm_steer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ipfm_pkg::cfg_t                       cfg,
	input  wire ipfm_pkg::steer_req_t                 req,
	output logic signed [ipfm_pkg::OFF_W-1:0]         fb
);

	logic signed [ipfm_pkg::OFF_W-1:0]  offset_prev_q;
	logic signed [ipfm_pkg::OFF_W:0]    diff;
	logic signed [ipfm_pkg::GAIN_W+ipfm_pkg::OFF_W:0]   p_kp;
	logic signed [ipfm_pkg::GAIN_W+ipfm_pkg::OFF_W+1:0] p_kd;
	logic signed [ipfm_pkg::SUM_W-1:0]  sum;

	assign diff = {req.offset[ipfm_pkg::OFF_W-1], req.offset}
		- {offset_prev_q[ipfm_pkg::OFF_W-1], offset_prev_q};
	assign p_kp = $signed({1'b0, cfg.steer_kp}) * req.offset;
	assign p_kd = $signed({1'b0, cfg.steer_kd}) * diff;
	assign sum  = ipfm_pkg::SUM_W'(p_kp) + ipfm_pkg::SUM_W'(p_kd);
	assign fb   = ipfm_pkg::sat8(ipfm_pkg::q8_trunc(sum));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_prev_q <= '0;
		end else if (req.upd) begin
			offset_prev_q <= req.offset;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ipfm_loop.sv @@
// input stage, per-motor loop state, pid increment and result register
// uses ipfm_pkg, incremental_pid_four_motor_defines.svh; fb comes from ipfm_steer
`default_nettype none
`include "incremental_pid_four_motor_defines.svh"
module ipfm_loop (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire ipfm_pkg::cfg_t                         cfg,
	input  wire logic signed [ipfm_pkg::OFF_W-1:0]      fb,
	output ipfm_pkg::steer_req_t                        steer_req,
	input  wire logic                                   item_valid,
	output logic                                        item_ready,
	input  wire logic [ipfm_pkg::ACTION_W-1:0]          action,
	input  wire logic [ipfm_pkg::MOTOR_IDX_W-1:0]       motor_index,
	input  wire logic signed [ipfm_pkg::SPEED_W-1:0]    speed_request,
	input  wire logic signed [ipfm_pkg::SPEED_W-1:0]    measured_count,
	input  wire logic signed [ipfm_pkg::OFF_W-1:0]      line_offset,
	output logic                                        result_valid,
	input  wire logic                                   result_ready,
	output logic signed [ipfm_pkg::SPEED_W-1:0]         pwm_increment,
	output logic signed [ipfm_pkg::SPEED_W-1:0]         measured_speed,
	output logic signed [ipfm_pkg::SPEED_W-1:0]         target_speed
);

	localparam int SW = ipfm_pkg::SPEED_W;
	localparam int EW = ipfm_pkg::ERR_W;
	localparam int GW = ipfm_pkg::GAIN_W;
	localparam int NM = ipfm_pkg::MOTOR_COUNT;

	// input stage
	logic                                 valid_s1;
	logic [ipfm_pkg::ACTION_W-1:0]        act_s1;
	logic [ipfm_pkg::MOTOR_IDX_W-1:0]     idx_s1;
	logic signed [SW-1:0]                 req_s1;
	logic signed [SW-1:0]                 meas_s1;
	logic signed [ipfm_pkg::OFF_W-1:0]    off_s1;

	// loop state
	logic signed [SW-1:0] target_q [NM];
	logic signed [SW-1:0] meas_q   [NM];
	logic signed [EW-1:0] ep_q     [NM];
	logic signed [EW-1:0] ep2_q    [NM];
	logic signed [SW-1:0] target_d [NM];
	logic signed [SW-1:0] meas_d   [NM];
	logic signed [EW-1:0] ep_d     [NM];
	logic signed [EW-1:0] ep2_d    [NM];

	// result register
	logic                 result_valid_q;
	logic signed [SW-1:0] pwm_q;
	logic signed [SW-1:0] meas_out_q;
	logic signed [SW-1:0] tgt_out_q;

	logic adv, take, step;

	logic signed [SW-1:0]   max_s, v, neg_v, left_t, right_t, tgt_cur;
	logic signed [SW:0]     neg_x, left_x, right_x;
	logic signed [EW-1:0]   e, e1, e2;
	logic signed [EW:0]     d1;
	logic signed [EW+1:0]   d2;
	logic signed [GW+EW+1:0] p_kp;
	logic signed [GW+EW:0]   p_ki;
	logic signed [GW+EW+2:0] p_kd;
	logic signed [ipfm_pkg::SUM_W-1:0] sum;
	logic signed [SW-1:0]   pwm_calc, pwm_d;

	// handshake: the input stage moves whenever the result register is free or drained
	assign adv        = !result_valid_q || result_ready;
	assign item_ready = !valid_s1 || adv;
	assign take       = item_valid && item_ready;
	assign step       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_s1  <= action;
			idx_s1  <= motor_index;
			req_s1  <= speed_request;
			meas_s1 <= measured_count;
			off_s1  <= line_offset;
		end
		if (step) begin
			pwm_q      <= pwm_d;
			meas_out_q <= meas_d[idx_s1];
			tgt_out_q  <= target_d[idx_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NM; i++) begin
				target_q[i] <= '0;
				meas_q[i]   <= '0;
				ep_q[i]     <= '0;
				ep2_q[i]    <= '0;
			end
		end else if (step) begin
			for (int i = 0; i < NM; i++) begin
				target_q[i] <= target_d[i];
				meas_q[i]   <= meas_d[i];
				ep_q[i]     <= ep_d[i];
				ep2_q[i]    <= ep2_d[i];
			end
		end
	end

	// capped request and the spin / steer targets
	assign max_s   = $signed({1'b0, cfg.max_speed});
	assign v       = (req_s1 > max_s) ? max_s : req_s1;
	assign neg_x   = -{v[SW-1], v};
	assign neg_v   = ipfm_pkg::sat17(neg_x);
	assign left_x  = {v[SW-1], v} + (SW+1)'(fb);
	assign right_x = {v[SW-1], v} - (SW+1)'(fb);
	assign left_t  = ipfm_pkg::sat17(left_x);
	assign right_t = ipfm_pkg::sat17(right_x);

	// incremental pid on the addressed motor
	assign tgt_cur  = target_q[idx_s1];
	assign e        = {tgt_cur[SW-1], tgt_cur} - {meas_s1[SW-1], meas_s1};
	assign e1       = ep_q[idx_s1];
	assign e2       = ep2_q[idx_s1];
	assign d1       = (EW+1)'(e) - (EW+1)'(e1);
	assign d2       = (EW+2)'(e) - ((EW+2)'(e1) <<< 1) + (EW+2)'(e2);
	assign p_kp     = $signed({1'b0, cfg.kp}) * d1;
	assign p_ki     = $signed({1'b0, cfg.ki}) * e;
	assign p_kd     = $signed({1'b0, cfg.kd}) * d2;
	assign sum      = ipfm_pkg::SUM_W'(p_kp) + ipfm_pkg::SUM_W'(p_ki)
		+ ipfm_pkg::SUM_W'(p_kd);
	assign pwm_calc = ipfm_pkg::sat16(ipfm_pkg::q8_trunc(sum));

	always_comb begin
		target_d = target_q;
		meas_d   = meas_q;
		ep_d     = ep_q;
		ep2_d    = ep2_q;
		pwm_d    = '0;
		case (act_s1)
			ipfm_pkg::ACT_COMPUTE: begin
				meas_d[idx_s1] = meas_s1;
				ep2_d[idx_s1]  = e1;
				ep_d[idx_s1]   = e;
				pwm_d          = pwm_calc;
			end
			ipfm_pkg::ACT_SET_ONE: begin
				target_d[idx_s1] = v;
			end
			ipfm_pkg::ACT_SET_ALL: begin
				for (int i = 0; i < NM; i++) begin
					target_d[i] = v;
				end
			end
			ipfm_pkg::ACT_SPIN: begin
				// odd motors are on the right side
				for (int i = 0; i < NM; i++) begin
					target_d[i] = i[0] ? neg_v : v;
				end
			end
			ipfm_pkg::ACT_STEER: begin
				for (int i = 0; i < NM; i++) begin
					target_d[i] = i[0] ? right_t : left_t;
				end
			end
			ipfm_pkg::ACT_CLEAR: begin
				for (int i = 0; i < NM; i++) begin
					target_d[i] = '0;
					meas_d[i]   = '0;
					ep_d[i]     = '0;
					ep2_d[i]    = '0;
				end
			end
			default: ;
		endcase
	end

	assign steer_req.upd    = step && (act_s1 == ipfm_pkg::ACT_STEER);
	assign steer_req.offset = off_s1;

	assign result_valid   = result_valid_q;
	assign pwm_increment  = pwm_q;
	assign measured_speed = meas_out_q;
	assign target_speed   = tgt_out_q;

	`IPFM_ASSERT(a_step_gives_result, step |=> result_valid_q, "beat in stage 1 lost")
	`IPFM_NEVER(a_ready_when_empty, !result_valid_q && !item_ready, "stalled with no result")
	`IPFM_ASSERT(a_pwm_only_compute, step && (act_s1 != ipfm_pkg::ACT_COMPUTE) |=> pwm_q == 0, "pwm on non-compute")
	`IPFM_ASSERT(a_clear_zeroes, step && (act_s1 == ipfm_pkg::ACT_CLEAR) |=> target_q[0] == 0 && target_q[3] == 0 && meas_q[1] == 0 && ep_q[2] == 0, "clear left state")
	`IPFM_ASSERT(a_set_all_equal, step && (act_s1 == ipfm_pkg::ACT_SET_ALL) |=> target_q[0] == target_q[1] && target_q[2] == target_q[3], "set all mismatch")

endmodule
`default_nettype wire
